// ----- rtl/core/twbb_pkg.sv -----
`timescale 1ns / 1ps

package twbb_pkg;

  // Field widths fixed by the word formats.
  localparam int SIZE_W = 31;
  localparam int TIME_W = 63;
  localparam int BYTE_W = 37;
  localparam int WORD_W = 64;
  localparam int CFG_W  = 64;

  // Defaults for the top-level parameters.
  localparam int DEF_RING_DEPTH = 64;
  localparam int DEF_TAG_BITS   = 16;

  // Operation codes carried by an input word.
  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_CLEAR = 2'd1,
    OP_QUERY = 2'd2,
    OP_NOP   = 2'd3
  } twbb_op_e;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    CFG_MEM_LIMIT = 1'b0,
    CFG_DUR_LIMIT = 1'b1
  } twbb_cfg_e;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_REV,
    ST_OVR,
    ST_EVM,
    ST_EVD,
    ST_FULL,
    ST_APPEND,
    ST_QFWD,
    ST_QBWD,
    ST_FINISH
  } twbb_state_e;

  // Request to the shared add/subtract and compare unit: (a +/- b) > c.
  typedef struct packed {
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
    logic [WORD_W-1:0] c;
    logic              sub;
  } twbb_alu_req_t;

endpackage

// ----- rtl/core/time_window_byte_budget_fifo.sv -----
`timescale 1ns / 1ps

// Ring of message records (size, timestamp, tag) with a running byte total. One input
// word is taken at a time and gives one result word. The result word sits in an output
// register, so the next word can be accepted while it waits; a further result that is
// still waiting holds the sequencer in its last state until the register is taken.
// A clear or an unused code goes straight to its result. A push tests for time reversal
// and for oversize, evicts records by the byte budget and then by the age span, one
// record per step, evicts the oldest record if the ring is still full, then appends;
// a push dropped as oversize goes to its result after the oversize test. A range query
// skips records from the front, then from the back, before its result. The steps are
// serial because of the record memory, which has a single registered read port and is
// walked one record per cycle, and because of the single add-and-compare unit that the
// size, time and range tests share. Data from unwritten record slots is never used, so
// the memory needs no clearing after reset.

module time_window_byte_budget_fifo import twbb_pkg::*; #(
  parameter int RING_DEPTH = DEF_RING_DEPTH,
  parameter int TAG_BITS   = DEF_TAG_BITS,
  localparam int IDX_W     = $clog2(RING_DEPTH),
  localparam int CNT_W     = $clog2(RING_DEPTH + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Configuration writes.
  input  logic                cfg_we_i,
  input  logic [0:0]          cfg_idx_i,
  input  logic [CFG_W-1:0]    cfg_data_i,
  // Input words.
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          operation_i,
  input  logic [SIZE_W-1:0]   msg_size_i,
  input  logic [TIME_W-1:0]   msg_time_i,
  input  logic [TAG_BITS-1:0] payload_tag_i,
  input  logic [TIME_W-1:0]   range_start_i,
  input  logic [TIME_W-1:0]   range_stop_i,
  // Result words.
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                stored_o,
  output logic                dropped_o,
  output logic                time_reversal_cleared_o,
  output logic [CNT_W-1:0]    evicted_count_o,
  output logic [CNT_W-1:0]    entry_count_o,
  output logic [BYTE_W-1:0]   byte_total_o,
  output logic [TIME_W-1:0]   oldest_time_o,
  output logic [TIME_W-1:0]   newest_time_o,
  output logic [CNT_W-1:0]    range_offset_o,
  output logic [CNT_W-1:0]    range_count_o
);

  twbb_state_e state_q, state_d;

  // Captured input word.
  twbb_op_e            op_q, op_d;
  logic [SIZE_W-1:0]   size_q, size_d;
  logic [TIME_W-1:0]   time_q, time_d;
  logic [TAG_BITS-1:0] tag_q, tag_d;
  logic [TIME_W-1:0]   start_q, start_d;
  logic [TIME_W-1:0]   stop_q, stop_d;

  // Ring status.
  logic [IDX_W-1:0]    head_q, head_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [BYTE_W-1:0]   bytes_q, bytes_d;
  logic [TIME_W-1:0]   newest_q, newest_d;

  // Limits.
  logic [31:0]         mem_limit_q;
  logic [CFG_W-1:0]    dur_limit_q;

  // Per-word flags and query bounds.
  logic                stored_q, stored_d;
  logic                dropped_q, dropped_d;
  logic                rev_q, rev_d;
  logic [CNT_W-1:0]    evicted_q, evicted_d;
  logic [CNT_W-1:0]    beg_q, beg_d;
  logic [CNT_W-1:0]    end_q, end_d;

  // Result register.
  logic                out_valid_q, out_valid_d;
  logic                res_stored_q, res_dropped_q, res_rev_q;
  logic [CNT_W-1:0]    res_evicted_q, res_count_q, res_off_q, res_rcnt_q;
  logic [BYTE_W-1:0]   res_bytes_q;
  logic [TIME_W-1:0]   res_wstart_q, res_wstop_q;

  // Memory and shared unit.
  logic                wr_en;
  logic [IDX_W-1:0]    wr_addr;
  logic [IDX_W-1:0]    rd_addr;
  logic [SIZE_W-1:0]   rd_size;
  logic [TIME_W-1:0]   rd_time;
  twbb_alu_req_t       alu_req;
  logic                alu_gt;

  logic                in_fire;
  logic                mem_on;
  logic                dur_on;
  logic                nonempty;
  logic                rev_go;
  logic                ovr_go;
  logic                evm_go;
  logic                evd_go;
  logic                full_go;
  logic                fwd_go;
  logic                bwd_go;
  logic                res_load;
  logic [CNT_W-1:0]    end_m1;
  logic [CNT_W-1:0]    end_m2;
  logic [TIME_W-1:0]   wstart;

  // Slot of a ring position counted from the given base slot.
  function automatic logic [IDX_W-1:0] slot_at(input logic [IDX_W-1:0] base,
                                               input logic [CNT_W-1:0] pos);
    logic [CNT_W:0] sum;
    sum = (CNT_W + 1)'(base) + (CNT_W + 1)'(pos);
    if (sum >= (CNT_W + 1)'(RING_DEPTH)) begin
      sum = sum - (CNT_W + 1)'(RING_DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

  twbb_ring #(
    .RING_DEPTH(RING_DEPTH),
    .TAG_BITS  (TAG_BITS)
  ) u_ring (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_size_i(size_q),
    .wr_time_i(time_q),
    .wr_tag_i (tag_q),
    .rd_addr_i(rd_addr),
    .rd_size_o(rd_size),
    .rd_time_o(rd_time)
  );

  twbb_alu u_alu (
    .req_i(alu_req),
    .gt_o (alu_gt)
  );

  // Decisions taken by the sequencer in the current state.
  assign in_fire  = in_valid_i & in_ready_o;
  assign mem_on   = ~mem_limit_q[31];
  assign dur_on   = ~dur_limit_q[CFG_W-1];
  assign nonempty = (count_q != '0);
  assign rev_go   = (state_q == ST_REV) && nonempty && alu_gt;
  assign ovr_go   = (state_q == ST_OVR) && mem_on && alu_gt;
  assign evm_go   = (state_q == ST_EVM) && mem_on && nonempty && alu_gt;
  assign evd_go   = (state_q == ST_EVD) && dur_on && nonempty && alu_gt;
  assign full_go  = (state_q == ST_FULL) && (count_q == CNT_W'(RING_DEPTH));
  assign fwd_go   = (state_q == ST_QFWD) && (start_q != '0) && (beg_q != end_q) && alu_gt;
  assign bwd_go   = (state_q == ST_QBWD) && (stop_q != '0) && (end_q != beg_q) && alu_gt;
  assign res_load = (state_q == ST_FINISH) && (!out_valid_q || out_ready_i);
  assign end_m1   = (end_q != '0) ? end_q - CNT_W'(1) : '0;
  assign end_m2   = (end_q > CNT_W'(1)) ? end_q - CNT_W'(2) : '0;

  // Operands of the shared unit for each test.
  always_comb begin
    alu_req = '0;
    case (state_q)
      ST_REV: begin
        alu_req.a = WORD_W'(newest_q);
        alu_req.c = WORD_W'(time_q);
      end
      ST_OVR: begin
        alu_req.a = WORD_W'(size_q);
        alu_req.c = WORD_W'(mem_limit_q);
      end
      ST_EVM: begin
        alu_req.a = WORD_W'(bytes_q);
        alu_req.b = WORD_W'(size_q);
        alu_req.c = WORD_W'(mem_limit_q);
      end
      ST_EVD: begin
        alu_req.a   = WORD_W'(time_q);
        alu_req.b   = WORD_W'(rd_time);
        alu_req.sub = 1'b1;
        alu_req.c   = dur_limit_q;
      end
      ST_QFWD: begin
        alu_req.a = WORD_W'(start_q);
        alu_req.c = WORD_W'(rd_time);
      end
      ST_QBWD: begin
        alu_req.a = WORD_W'(rd_time);
        alu_req.c = WORD_W'(stop_q);
      end
      default: begin
        alu_req = '0;
      end
    endcase
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          case (twbb_op_e'(operation_i))
            OP_PUSH:  state_d = ST_REV;
            OP_QUERY: state_d = ST_QFWD;
            default:  state_d = ST_FINISH;
          endcase
        end
      end
      ST_REV:    state_d = ST_OVR;
      ST_OVR:    state_d = ovr_go ? ST_FINISH : ST_EVM;
      ST_EVM:    state_d = evm_go ? ST_EVM : ST_EVD;
      ST_EVD:    state_d = evd_go ? ST_EVD : ST_FULL;
      ST_FULL:   state_d = ST_APPEND;
      ST_APPEND: state_d = ST_FINISH;
      ST_QFWD:   state_d = fwd_go ? ST_QFWD : ST_QBWD;
      ST_QBWD:   state_d = bwd_go ? ST_QBWD : ST_FINISH;
      ST_FINISH: state_d = res_load ? ST_IDLE : ST_FINISH;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Datapath updates and memory control.
  always_comb begin
    op_d      = op_q;
    size_d    = size_q;
    time_d    = time_q;
    tag_d     = tag_q;
    start_d   = start_q;
    stop_d    = stop_q;
    head_d    = head_q;
    count_d   = count_q;
    bytes_d   = bytes_q;
    newest_d  = newest_q;
    stored_d  = stored_q;
    dropped_d = dropped_q;
    rev_d     = rev_q;
    evicted_d = evicted_q;
    beg_d     = beg_q;
    end_d     = end_q;
    wr_en     = 1'b0;
    wr_addr   = slot_at(head_q, count_q);

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          op_d      = twbb_op_e'(operation_i);
          size_d    = msg_size_i;
          time_d    = msg_time_i;
          tag_d     = payload_tag_i;
          start_d   = range_start_i;
          stop_d    = range_stop_i;
          stored_d  = 1'b0;
          dropped_d = 1'b0;
          rev_d     = 1'b0;
          evicted_d = '0;
          beg_d     = '0;
          end_d     = count_q;
          if (twbb_op_e'(operation_i) == OP_CLEAR) begin
            head_d  = '0;
            count_d = '0;
            bytes_d = '0;
          end
        end
      end
      ST_REV: begin
        // An older timestamp than the newest record empties the ring.
        if (rev_go) begin
          head_d  = '0;
          count_d = '0;
          bytes_d = '0;
          rev_d   = 1'b1;
        end
      end
      ST_OVR: begin
        if (ovr_go) begin
          dropped_d = 1'b1;
        end
      end
      ST_EVM, ST_EVD, ST_FULL: begin
        // Evict the oldest record; its size is on the read port.
        if (evm_go || evd_go || full_go) begin
          bytes_d   = bytes_q - BYTE_W'(rd_size);
          head_d    = slot_at(head_q, CNT_W'(1));
          count_d   = count_q - CNT_W'(1);
          evicted_d = evicted_q + CNT_W'(1);
        end
      end
      ST_APPEND: begin
        wr_en    = 1'b1;
        count_d  = count_q + CNT_W'(1);
        bytes_d  = bytes_q + BYTE_W'(size_q);
        newest_d = time_q;
        stored_d = 1'b1;
      end
      ST_QFWD: begin
        if (fwd_go) begin
          beg_d = beg_q + CNT_W'(1);
        end
      end
      ST_QBWD: begin
        if (bwd_go) begin
          end_d = end_m1;
        end
      end
      default: begin
      end
    endcase

    // The read port normally follows the oldest record; the query walks point it
    // at the next record to test.
    rd_addr = head_d;
    case (state_q)
      ST_QFWD: rd_addr = fwd_go ? slot_at(head_q, beg_q + CNT_W'(1)) : slot_at(head_q, end_m1);
      ST_QBWD: rd_addr = bwd_go ? slot_at(head_q, end_m2) : head_q;
      default: rd_addr = head_d;
    endcase
  end

  // Oldest time: with a single record it is the newest one, which may have been
  // written too recently to show on the read port.
  always_comb begin
    if (count_q == '0) begin
      wstart = '0;
    end else if (count_q == CNT_W'(1)) begin
      wstart = newest_q;
    end else begin
      wstart = rd_time;
    end
  end

  // Result word handshake.
  always_comb begin
    out_valid_d = out_valid_q;
    if (res_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Control state and limits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      count_q     <= '0;
      bytes_q     <= '0;
      out_valid_q <= 1'b0;
      mem_limit_q <= '1;
      dur_limit_q <= '1;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      count_q     <= count_d;
      bytes_q     <= bytes_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (twbb_cfg_e'(cfg_idx_i))
          CFG_MEM_LIMIT: mem_limit_q <= cfg_data_i[31:0];
          CFG_DUR_LIMIT: dur_limit_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    size_q    <= size_d;
    time_q    <= time_d;
    tag_q     <= tag_d;
    start_q   <= start_d;
    stop_q    <= stop_d;
    newest_q  <= newest_d;
    stored_q  <= stored_d;
    dropped_q <= dropped_d;
    rev_q     <= rev_d;
    evicted_q <= evicted_d;
    beg_q     <= beg_d;
    end_q     <= end_d;
    if (res_load) begin
      res_stored_q  <= stored_q;
      res_dropped_q <= dropped_q;
      res_rev_q     <= rev_q;
      res_evicted_q <= evicted_q;
      res_count_q   <= count_q;
      res_bytes_q   <= bytes_q;
      res_wstart_q  <= wstart;
      res_wstop_q   <= nonempty ? newest_q : '0;
      res_off_q     <= (op_q == OP_QUERY) ? beg_q : '0;
      res_rcnt_q    <= (op_q == OP_QUERY) ? end_q - beg_q : '0;
    end
  end

  assign in_ready_o              = (state_q == ST_IDLE);
  assign out_valid_o             = out_valid_q;
  assign stored_o                = res_stored_q;
  assign dropped_o               = res_dropped_q;
  assign time_reversal_cleared_o = res_rev_q;
  assign evicted_count_o         = res_evicted_q;
  assign entry_count_o           = res_count_q;
  assign byte_total_o            = res_bytes_q;
  assign oldest_time_o           = res_wstart_q;
  assign newest_time_o           = res_wstop_q;
  assign range_offset_o          = res_off_q;
  assign range_count_o           = res_rcnt_q;

endmodule

// ----- rtl/core/twbb_ring.sv -----
`timescale 1ns / 1ps

module twbb_ring import twbb_pkg::*; #(
  parameter int RING_DEPTH = DEF_RING_DEPTH,
  parameter int TAG_BITS   = DEF_TAG_BITS,
  localparam int IDX_W     = $clog2(RING_DEPTH)
) (
  input  logic                clk_i,
  input  logic                wr_en_i,
  input  logic [IDX_W-1:0]    wr_addr_i,
  input  logic [SIZE_W-1:0]   wr_size_i,
  input  logic [TIME_W-1:0]   wr_time_i,
  input  logic [TAG_BITS-1:0] wr_tag_i,
  input  logic [IDX_W-1:0]    rd_addr_i,
  output logic [SIZE_W-1:0]   rd_size_o,
  output logic [TIME_W-1:0]   rd_time_o
);

  logic [SIZE_W-1:0]   size_mem_q [RING_DEPTH];
  logic [TIME_W-1:0]   time_mem_q [RING_DEPTH];
  logic [TAG_BITS-1:0] tag_mem_q  [RING_DEPTH];
  logic [SIZE_W-1:0]   rd_size_q;
  logic [TIME_W-1:0]   rd_time_q;

  // One write port and one registered read port; a read at the written
  // address returns the old record.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      size_mem_q[wr_addr_i] <= wr_size_i;
      time_mem_q[wr_addr_i] <= wr_time_i;
      tag_mem_q[wr_addr_i]  <= wr_tag_i;
    end
    rd_size_q <= size_mem_q[rd_addr_i];
    rd_time_q <= time_mem_q[rd_addr_i];
  end

  assign rd_size_o = rd_size_q;
  assign rd_time_o = rd_time_q;

endmodule

// ----- rtl/core/twbb_alu.sv -----
`timescale 1ns / 1ps

module twbb_alu import twbb_pkg::*; (
  input  twbb_alu_req_t req_i,
  output logic          gt_o
);

  logic [WORD_W-1:0] sum;

  // Add or subtract, then compare against the limit operand.
  always_comb begin
    if (req_i.sub) begin
      sum = req_i.a - req_i.b;
    end else begin
      sum = req_i.a + req_i.b;
    end
    gt_o = (sum > req_i.c);
  end

endmodule

// ----- rtl/core/twbb_checker.sv -----
`timescale 1ns / 1ps

module twbb_checker import twbb_pkg::*; #(
  parameter int RING_DEPTH = DEF_RING_DEPTH,
  localparam int CNT_W     = $clog2(RING_DEPTH + 1)
) (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input logic              stored_o,
  input logic              dropped_o,
  input logic [CNT_W-1:0]  entry_count_o,
  input logic [BYTE_W-1:0] byte_total_o,
  input logic [TIME_W-1:0] oldest_time_o,
  input logic [TIME_W-1:0] newest_time_o
);

  // The ring never reports more records than it has slots.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (entry_count_o <= CNT_W'(RING_DEPTH)))
    else $error("entry count beyond ring depth");

  // An empty ring holds no bytes and has no time window.
  a_empty_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (entry_count_o == '0)) |->
      ((byte_total_o == '0) && (oldest_time_o == '0) && (newest_time_o == '0)))
    else $error("empty ring reports a nonzero status");

  // A push is either stored or dropped, never both.
  a_push_outcome: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(stored_o && dropped_o))
    else $error("word both stored and dropped");

  // Records are kept in time order, so the window never runs backwards.
  a_window_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (oldest_time_o <= newest_time_o))
    else $error("oldest time after newest time");

  // A stalled result word holds.
  a_result_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(byte_total_o) && $stable(entry_count_o)))
    else $error("result word changed while stalled");

endmodule

bind time_window_byte_budget_fifo twbb_checker #(
  .RING_DEPTH(RING_DEPTH)
) u_twbb_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .stored_o     (stored_o),
  .dropped_o    (dropped_o),
  .entry_count_o(entry_count_o),
  .byte_total_o (byte_total_o),
  .oldest_time_o(oldest_time_o),
  .newest_time_o(newest_time_o)
);
